>>> hdl/gil_pkg.sv
// Package for grid_index_linearizer: widths, register codes, pipeline types.
// No dependencies.
package gil_pkg;

	localparam int LIN_W         = 36;
	localparam int CRD_W         = 12;
	localparam int SZ_W          = 13;
	localparam int CIN_W         = 13;
	localparam int DIM_W         = 2;
	localparam int CFG_IDX_W     = 2;
	localparam int MAX_AXIS_SIZE = 4096;
	localparam int MAX_AXES      = 3;
	localparam int MID_W         = CRD_W + SZ_W;
	localparam int DIV_STEPS     = LIN_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DIMS  = 2'd0,
		REG_SIZE0 = 2'd1,
		REG_SIZE1 = 2'd2,
		REG_SIZE2 = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [DIM_W-1:0] dims;
		logic [SZ_W-1:0]  size0;
		logic [SZ_W-1:0]  size1;
		logic [SZ_W-1:0]  size2;
	} cfg_t;

	typedef struct packed {
		logic [LIN_W-1:0] num;
		logic [CRD_W-1:0] rem;
		logic [SZ_W-1:0]  dvs;
	} div_t;

	typedef struct packed {
		logic             cmd;
		logic             bad;
		logic [DIM_W-1:0] dims;
		logic [LIN_W-1:0] lin;
		div_t             a;
		logic [SZ_W-1:0]  dvs_m;
		logic [SZ_W-1:0]  s0;
		logic [CRD_W-1:0] r_fast;
	} item_t;

	function automatic logic [SZ_W-1:0] eff_size(input logic [SZ_W-1:0] s);
		logic [SZ_W-1:0] r;
		r = s;
		if (s == '0) begin
			r = SZ_W'(1);
		end else if (s > SZ_W'(MAX_AXIS_SIZE)) begin
			r = SZ_W'(MAX_AXIS_SIZE);
		end
		return r;
	endfunction

	function automatic logic [DIM_W-1:0] eff_dims(input logic [DIM_W-1:0] d);
		logic [DIM_W-1:0] r;
		r = d;
		if (d == '0) begin
			r = DIM_W'(1);
		end else if (d > DIM_W'(MAX_AXES)) begin
			r = DIM_W'(MAX_AXES);
		end
		return r;
	endfunction

endpackage

>>> hdl/gil_if.sv
// Channel interfaces for grid_index_linearizer: request and result.
// Depends on gil_pkg.
interface gil_req_if import gil_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             cmd;
	logic [CIN_W-1:0] coord_in0;
	logic [CIN_W-1:0] coord_in1;
	logic [CIN_W-1:0] coord_in2;
	logic [LIN_W-1:0] linear_in;

	modport source (output valid, cmd, coord_in0, coord_in1, coord_in2, linear_in,
		input ready);
	modport sink (input valid, cmd, coord_in0, coord_in1, coord_in2, linear_in,
		output ready);
endinterface

interface gil_rsp_if import gil_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [LIN_W-1:0] linear_out;
	logic [CRD_W-1:0] coord_out0;
	logic [CRD_W-1:0] coord_out1;
	logic [CRD_W-1:0] coord_out2;
	logic             out_of_range;

	modport source (output valid, linear_out, coord_out0, coord_out1, coord_out2,
		out_of_range, input ready);
	modport sink (input valid, linear_out, coord_out0, coord_out1, coord_out2,
		out_of_range, output ready);
endinterface

>>> hdl/gil_front.sv
// Front end: bounds check, negative wrap, axis mapping, two-stage linearize.
// Depends on gil_pkg.
module gil_front import gil_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             cmd,
	input  logic [CIN_W-1:0] coord_in0,
	input  logic [CIN_W-1:0] coord_in1,
	input  logic [CIN_W-1:0] coord_in2,
	input  logic [LIN_W-1:0] linear_in,
	output logic             out_valid,
	input  logic             out_ready,
	output item_t            out_item
);

	typedef struct packed {
		logic             cmd;
		logic             bad;
		logic [DIM_W-1:0] dims;
		logic [CRD_W-1:0] w0;
		logic [CRD_W-1:0] w1;
		logic [CRD_W-1:0] w2;
		logic [SZ_W-1:0]  m;
		logic [SZ_W-1:0]  f;
		logic [SZ_W-1:0]  s0;
		logic [LIN_W-1:0] pos;
	} f1_t;

	typedef struct packed {
		logic             cmd;
		logic             bad;
		logic [DIM_W-1:0] dims;
		logic [MID_W-1:0] t;
		logic [CRD_W-1:0] w2;
		logic [SZ_W-1:0]  m;
		logic [SZ_W-1:0]  f;
		logic [SZ_W-1:0]  s0;
		logic [LIN_W-1:0] pos;
	} f2_t;

	logic [2:0][SZ_W-1:0]  sz;
	logic [2:0][CIN_W-1:0] cin;
	logic [2:0][CRD_W-1:0] wr;
	logic [2:0]            ok;
	logic [DIM_W-1:0]      d;
	f1_t                   f1_d, f1_s1;
	f2_t                   f2_d, f2_s2;
	item_t                 f3_d, f3_s3;
	logic                  v1_q, v2_q, v3_q;
	logic                  rdy1, rdy2, rdy3;
	logic [SZ_W+CRD_W-1:0] mul1;
	logic [MID_W+SZ_W-1:0] mul2;

	assign sz[0] = eff_size(cfg.size0);
	assign sz[1] = eff_size(cfg.size1);
	assign sz[2] = eff_size(cfg.size2);
	assign cin[0] = coord_in0;
	assign cin[1] = coord_in1;
	assign cin[2] = coord_in2;
	assign d = eff_dims(cfg.dims);

	always_comb begin
		logic signed [CIN_W:0] cs, ss, wv;
		for (int k = 0; k < 3; k++) begin
			cs = $signed({cin[k][CIN_W-1], cin[k]});
			ss = $signed({1'b0, sz[k]});
			ok[k] = (cs >= -ss) && (cs < ss);
			wv = cs[CIN_W] ? cs + ss : cs;
			wr[k] = wv[CRD_W-1:0];
		end
	end

	always_comb begin
		f1_d = '0;
		f1_d.cmd = cmd;
		f1_d.dims = d;
		f1_d.s0 = sz[0];
		f1_d.pos = linear_in;
		case (d)
			2'd3: begin
				f1_d.bad = !(ok[0] && ok[1] && ok[2]);
				f1_d.w0 = wr[0];
				f1_d.w1 = wr[1];
				f1_d.w2 = wr[2];
				f1_d.m = sz[1];
				f1_d.f = sz[2];
			end
			2'd2: begin
				f1_d.bad = !(ok[0] && ok[1]);
				f1_d.w1 = wr[0];
				f1_d.w2 = wr[1];
				f1_d.m = SZ_W'(1);
				f1_d.f = sz[1];
			end
			default: begin
				f1_d.bad = !ok[0];
				f1_d.w2 = wr[0];
				f1_d.m = SZ_W'(1);
				f1_d.f = SZ_W'(1);
			end
		endcase
		if (!cmd) begin
			f1_d.bad = f1_d.bad;
		end else begin
			f1_d.bad = 1'b0;
		end
	end

	assign mul1 = f1_s1.w0 * f1_s1.m;
	always_comb begin
		f2_d.cmd = f1_s1.cmd;
		f2_d.bad = f1_s1.bad;
		f2_d.dims = f1_s1.dims;
		f2_d.t = MID_W'(mul1) + MID_W'(f1_s1.w1);
		f2_d.w2 = f1_s1.w2;
		f2_d.m = f1_s1.m;
		f2_d.f = f1_s1.f;
		f2_d.s0 = f1_s1.s0;
		f2_d.pos = f1_s1.pos;
	end

	assign mul2 = f2_s2.t * f2_s2.f;
	always_comb begin
		f3_d.cmd = f2_s2.cmd;
		f3_d.bad = f2_s2.bad;
		f3_d.dims = f2_s2.dims;
		f3_d.lin = (f2_s2.bad || f2_s2.cmd) ? '0 :
			LIN_W'(mul2) + LIN_W'(f2_s2.w2);
		f3_d.a.num = f2_s2.pos;
		f3_d.a.rem = '0;
		f3_d.a.dvs = f2_s2.f;
		f3_d.dvs_m = f2_s2.m;
		f3_d.s0 = f2_s2.s0;
		f3_d.r_fast = '0;
	end

	assign rdy3 = !v3_q || out_ready;
	assign rdy2 = !v2_q || rdy3;
	assign rdy1 = !v1_q || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (rdy1) v1_q <= in_valid;
			if (rdy2) v2_q <= v1_q;
			if (rdy3) v3_q <= v2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) f1_s1 <= f1_d;
		if (rdy2 && v1_q) f2_s2 <= f2_d;
		if (rdy3 && v2_q) f3_s3 <= f3_d;
	end

	assign out_valid = v3_q;
	assign out_item = f3_s3;

endmodule

>>> hdl/gil_div_cell.sv
// One restoring division step on the item's divide field, with its own stage.
// Depends on gil_pkg.
module gil_div_cell import gil_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	output logic  out_valid,
	input  logic  out_ready,
	output item_t out_item
);

	logic            v_q;
	item_t           item_q;
	item_t           nxt;
	logic [SZ_W-1:0] trial;
	logic            qbit;

	assign trial = {in_item.a.rem, in_item.a.num[LIN_W-1]};
	assign qbit = trial >= in_item.a.dvs;

	always_comb begin
		nxt = in_item;
		nxt.a.num = {in_item.a.num[LIN_W-2:0], qbit};
		nxt.a.rem = qbit ? CRD_W'(trial - in_item.a.dvs) : trial[CRD_W-1:0];
	end

	assign in_ready = !v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) item_q <= nxt;
	end

	assign out_valid = v_q;
	assign out_item = item_q;

endmodule

>>> hdl/gil_handoff.sv
// Stage between the two divide chains: saves the fast remainder and loads
// the middle-axis divisor. Depends on gil_pkg.
module gil_handoff import gil_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	output logic  out_valid,
	input  logic  out_ready,
	output item_t out_item
);

	logic  v_q;
	item_t item_q;
	item_t nxt;

	always_comb begin
		nxt = in_item;
		nxt.r_fast = in_item.a.rem;
		nxt.a.rem = '0;
		nxt.a.dvs = in_item.dvs_m;
	end

	assign in_ready = !v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) item_q <= nxt;
	end

	assign out_valid = v_q;
	assign out_item = item_q;

endmodule

>>> hdl/grid_index_linearizer.sv
// Top level: config registers, front end, two chains of divide cells, result register.
// Depends on gil_pkg, gil_if, gil_front, gil_div_cell, gil_handoff.
//
//  channel | dir | handshake     | payload
//  req     | in  | valid/ready   | cmd, coord_in0..2, linear_in
//  rsp     | out | valid/ready   | linear_out, coord_out0..2, out_of_range
//  cfg     | in  | cfg_we        | cfg_index, cfg_data
//
// One transaction per cycle sustained while rsp accepts results; the two
// 36-cell restoring divide chains sit between front end and result register.
// Every stage holds its own valid; bubbles close up while rsp is stalled.
// Reset clears all valids and loads the register defaults.
module grid_index_linearizer import gil_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SZ_W-1:0]      cfg_data,
	gil_req_if.sink              req,
	gil_rsp_if.source            rsp
);

	cfg_t  cfg_q;
	logic  [DIV_STEPS:0] va, ra, vb, rb;
	item_t [DIV_STEPS:0] ia, ib;
	logic  ov_q;
	logic  ordy;
	item_t fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dims  <= DIM_W'(3);
			cfg_q.size0 <= SZ_W'(1);
			cfg_q.size1 <= SZ_W'(1);
			cfg_q.size2 <= SZ_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DIMS:  cfg_q.dims  <= cfg_data[DIM_W-1:0];
				REG_SIZE0: cfg_q.size0 <= cfg_data;
				REG_SIZE1: cfg_q.size1 <= cfg_data;
				REG_SIZE2: cfg_q.size2 <= cfg_data;
				default: ;
			endcase
		end
	end

	gil_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.cmd       (req.cmd),
		.coord_in0 (req.coord_in0),
		.coord_in1 (req.coord_in1),
		.coord_in2 (req.coord_in2),
		.linear_in (req.linear_in),
		.out_valid (va[0]),
		.out_ready (ra[0]),
		.out_item  (ia[0])
	);

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_chain_a
		gil_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (va[k]),
			.in_ready  (ra[k]),
			.in_item   (ia[k]),
			.out_valid (va[k+1]),
			.out_ready (ra[k+1]),
			.out_item  (ia[k+1])
		);
	end

	gil_handoff u_handoff (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (va[DIV_STEPS]),
		.in_ready  (ra[DIV_STEPS]),
		.in_item   (ia[DIV_STEPS]),
		.out_valid (vb[0]),
		.out_ready (rb[0]),
		.out_item  (ib[0])
	);

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_chain_b
		gil_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (vb[k]),
			.in_ready  (rb[k]),
			.in_item   (ib[k]),
			.out_valid (vb[k+1]),
			.out_ready (rb[k+1]),
			.out_item  (ib[k+1])
		);
	end

	assign fin = ib[DIV_STEPS];
	assign ordy = !ov_q || rsp.ready;
	assign rb[DIV_STEPS] = ordy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (ordy) begin
			ov_q <= vb[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		logic bad1;
		bad1 = fin.a.num >= LIN_W'(fin.s0);
		if (ordy && vb[DIV_STEPS]) begin
			rsp.linear_out <= fin.lin;
			rsp.coord_out0 <= '0;
			rsp.coord_out1 <= '0;
			rsp.coord_out2 <= '0;
			if (!fin.cmd) begin
				rsp.out_of_range <= fin.bad;
			end else begin
				rsp.out_of_range <= bad1;
				if (!bad1) begin
					rsp.coord_out0 <= fin.a.num[CRD_W-1:0];
					if (fin.dims == 2'd3) begin
						rsp.coord_out1 <= fin.a.rem;
						rsp.coord_out2 <= fin.r_fast;
					end else if (fin.dims == 2'd2) begin
						rsp.coord_out1 <= fin.r_fast;
					end
				end
			end
		end
	end

	assign rsp.valid = ov_q;

endmodule
